// ===== rtl/mcrqs_pkg.sv =====
`timescale 1ns / 1ps

package mcrqs_pkg;

	localparam int MAX_PROCS_DEF = 16;
	localparam int MAX_CPUS_DEF  = 8;
	localparam int PRIO_BITS_DEF = 8;

	localparam int OPC_W      = 3;
	localparam int CPU_W      = 3;
	localparam int PID_W      = 4;
	localparam int PRIO_IN_W  = 8;
	localparam int ACT_W      = 2;
	localparam int SLICE_W    = 16;
	localparam int MODE_W     = 2;
	localparam int NCPU_W     = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [OPC_W-1:0] OP_WAKE    = 3'd0;
	localparam logic [OPC_W-1:0] OP_PREEMPT = 3'd1;
	localparam logic [OPC_W-1:0] OP_YIELD   = 3'd2;
	localparam logic [OPC_W-1:0] OP_TERM    = 3'd3;
	localparam logic [OPC_W-1:0] OP_IDLE    = 3'd4;

	localparam logic [ACT_W-1:0] ACT_DISPATCH = 2'd0;
	localparam logic [ACT_W-1:0] ACT_IDLE     = 2'd1;
	localparam logic [ACT_W-1:0] ACT_PREEMPT  = 2'd2;
	localparam logic [ACT_W-1:0] ACT_FULL     = 2'd3;

	localparam logic [MODE_W-1:0] MODE_PRIO = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLICE  = 2'd2;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_cmd_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic set_busy;
		logic clr_busy;
	} cpu_cmd_t;

endpackage

// ===== rtl/multi_cpu_ready_queue_scheduler.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// item      in         item_valid/item_stall   opcode, cpu_index, process_id, proc_priority
// result    out        result_valid/result_stall action, target_cpu, dispatched_id, slice_out
// cfg       in         cfg_wr_en               cfg_index, cfg_data
//
// One item at a time. A wake-up pushes onto the queue and, in priority mode
// with every active CPU busy, scans the CPU table for a preemption. A dispatch
// scans the queue (queue length in priority mode, one entry otherwise), then
// shifts the entries behind the taken one to close the gap, one entry a cycle through the queue RAM.
// Reset clears the queue count, busy flags and output valid; no clearing pass.
// A held result stalls the next item only in S_DONE, and only when that item has a result to send.

module multi_cpu_ready_queue_scheduler #(
	parameter int MAX_PROCS = mcrqs_pkg::MAX_PROCS_DEF,
	parameter int MAX_CPUS  = mcrqs_pkg::MAX_CPUS_DEF,
	parameter int PRIO_BITS = mcrqs_pkg::PRIO_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [mcrqs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mcrqs_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic [mcrqs_pkg::OPC_W-1:0]       opcode,
	input  logic [mcrqs_pkg::CPU_W-1:0]       cpu_index,
	input  logic [mcrqs_pkg::PID_W-1:0]       process_id,
	input  logic [mcrqs_pkg::PRIO_IN_W-1:0]   proc_priority,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [mcrqs_pkg::ACT_W-1:0]       action,
	output logic [mcrqs_pkg::CPU_W-1:0]       target_cpu,
	output logic [mcrqs_pkg::PID_W-1:0]       dispatched_id,
	output logic [mcrqs_pkg::SLICE_W-1:0]     slice_out
);
	import mcrqs_pkg::*;

	localparam int QAW = $clog2(MAX_PROCS);
	localparam int QCW = $clog2(MAX_PROCS + 1);
	localparam int CAW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PRE_PUSH,
		S_CPU_SCAN,
		S_CPU_FIN,
		S_DISP,
		S_Q_SCAN,
		S_TAKE,
		S_SHIFT,
		S_DONE
	} state_t;

	state_t state_q;

	logic [MODE_W-1:0]  mode_q;
	logic [NCPU_W-1:0]  active_q;
	logic [SLICE_W-1:0] slice_q;

	logic [CPU_W-1:0]     cpu_q;
	logic [PRIO_BITS-1:0] prio_q;
	logic [QCW-1:0]       count_q;
	logic [QCW-1:0]       idx_q;
	logic [QCW-1:0]       limit_q;
	logic                 v_s1;
	logic [QAW-1:0]       qidx_s1;
	logic [QAW-1:0]       best_pos_q;
	logic [PID_W-1:0]     best_id_q;
	logic [PRIO_BITS-1:0] best_prio_q;
	logic [NCPU_W-1:0]    cidx_q;
	logic                 cv_s1;
	logic [NCPU_W-1:0]    cidx_s1;
	logic                 urgent_q;
	logic [PRIO_BITS-1:0] bestp_q;
	logic [NCPU_W-1:0]    bestc_q;

	logic                 res_pend_q;
	logic [ACT_W-1:0]     res_act_q;
	logic [CPU_W-1:0]     res_cpu_q;
	logic [PID_W-1:0]     res_id_q;
	logic [SLICE_W-1:0]   res_slice_q;

	logic                 result_valid_q;
	logic [ACT_W-1:0]     action_q;
	logic [CPU_W-1:0]     target_cpu_q;
	logic [PID_W-1:0]     dispatched_id_q;
	logic [SLICE_W-1:0]   slice_out_q;

	mem_cmd_t             q_cmd;
	logic [QAW-1:0]       q_wr_addr;
	logic [PID_W-1:0]     q_wr_id;
	logic [PRIO_BITS-1:0] q_wr_prio;
	logic [QAW-1:0]       q_rd_addr;
	logic [PID_W-1:0]     q_rd_id;
	logic [PRIO_BITS-1:0] q_rd_prio;

	cpu_cmd_t             c_cmd;
	logic [CAW-1:0]       c_addr;
	logic [CAW-1:0]       c_rd_addr;
	logic [PID_W-1:0]     c_rd_id;
	logic [PRIO_BITS-1:0] c_rd_prio;
	logic [MAX_CPUS-1:0]  busy;

	logic [NCPU_W-1:0]    n_eff;
	logic                 all_busy;
	logic                 q_full;
	logic                 cpu_ok;
	logic                 acc;
	logic [PRIO_BITS-1:0] prio_in;
	logic [QCW-1:0]       idx_m1;
	logic [QCW-1:0]       next_pos;
	logic                 in_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= '0;
			active_q <= NCPU_W'(1);
			slice_q  <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MODE:   mode_q   <= cfg_data[MODE_W-1:0];
				REG_ACTIVE: active_q <= cfg_data[NCPU_W-1:0];
				REG_SLICE:  slice_q  <= cfg_data[SLICE_W-1:0];
				default:    ;
			endcase
		end
	end

	assign n_eff      = (int'(active_q) > MAX_CPUS) ? NCPU_W'(MAX_CPUS) : active_q;
	assign q_full     = (count_q >= QCW'(MAX_PROCS));
	assign cpu_ok     = ({1'b0, cpu_index} < n_eff);
	assign item_stall = (state_q != S_IDLE);
	assign acc        = item_valid && !item_stall;
	assign prio_in    = PRIO_BITS'(proc_priority);
	assign idx_m1     = idx_q - QCW'(1);
	assign next_pos   = QCW'(best_pos_q) + QCW'(1);
	assign in_busy    = busy[CAW'(cpu_index)];

	always_comb begin
		all_busy = 1'b1;
		for (int i = 0; i < MAX_CPUS; i++) begin
			if (i < int'(n_eff) && !busy[i]) begin
				all_busy = 1'b0;
			end
		end
	end

	always_comb begin
		q_cmd     = '0;
		q_wr_addr = count_q[QAW-1:0];
		q_wr_id   = process_id;
		q_wr_prio = prio_in;
		q_rd_addr = idx_q[QAW-1:0];
		c_cmd     = '0;
		c_addr    = CAW'(cpu_q);
		c_rd_addr = CAW'(cidx_q);
		case (state_q)
			S_IDLE: begin
				c_addr    = CAW'(cpu_index);
				c_rd_addr = CAW'(cpu_index);
				if (acc) begin
					case (opcode)
						OP_WAKE: q_cmd.wr_en = !q_full;
						OP_PREEMPT: c_cmd.rd_en = cpu_ok && in_busy && !q_full;
						OP_YIELD, OP_TERM: c_cmd.clr_busy = cpu_ok;
						default: ;
					endcase
				end
			end
			S_PRE_PUSH: begin
				q_cmd.wr_en    = 1'b1;
				q_wr_id        = c_rd_id;
				q_wr_prio      = c_rd_prio;
				c_cmd.clr_busy = 1'b1;
			end
			S_CPU_SCAN: c_cmd.rd_en = (cidx_q < n_eff);
			S_DISP: c_cmd.clr_busy = (count_q == '0);
			S_Q_SCAN: q_cmd.rd_en = (idx_q < limit_q);
			S_TAKE: begin
				c_cmd.wr_en    = 1'b1;
				c_cmd.set_busy = 1'b1;
			end
			S_SHIFT: begin
				q_cmd.rd_en = (idx_q < count_q);
				q_cmd.wr_en = v_s1;
				q_wr_addr   = qidx_s1;
				q_wr_id     = q_rd_id;
				q_wr_prio   = q_rd_prio;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			cpu_q           <= '0;
			prio_q          <= '0;
			count_q         <= '0;
			idx_q           <= '0;
			limit_q         <= '0;
			v_s1            <= 1'b0;
			qidx_s1         <= '0;
			best_pos_q      <= '0;
			best_id_q       <= '0;
			best_prio_q     <= '0;
			cidx_q          <= '0;
			cv_s1           <= 1'b0;
			cidx_s1         <= '0;
			urgent_q        <= 1'b0;
			bestp_q         <= '0;
			bestc_q         <= '0;
			res_pend_q      <= 1'b0;
			res_act_q       <= '0;
			res_cpu_q       <= '0;
			res_id_q        <= '0;
			res_slice_q     <= '0;
			result_valid_q  <= 1'b0;
			action_q        <= '0;
			target_cpu_q    <= '0;
			dispatched_id_q <= '0;
			slice_out_q     <= '0;
		end else begin
			if (result_valid_q && !result_stall && !(state_q == S_DONE && res_pend_q)) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					res_pend_q  <= acc && q_full && (opcode == OP_WAKE ||
						(opcode == OP_PREEMPT && cpu_ok && in_busy));
					res_id_q    <= '0;
					res_slice_q <= '0;
					if (acc) begin
						cpu_q  <= cpu_index;
						prio_q <= prio_in;
						case (opcode)
							OP_WAKE: begin
								if (q_full) begin
									res_act_q <= ACT_FULL;
									res_cpu_q <= '0;
									state_q   <= S_DONE;
								end else begin
									count_q <= count_q + QCW'(1);
									if (mode_q == MODE_PRIO && n_eff != '0 && all_busy) begin
										cidx_q   <= '0;
										cv_s1    <= 1'b0;
										urgent_q <= 1'b0;
										bestp_q  <= '0;
										bestc_q  <= '0;
										state_q  <= S_CPU_SCAN;
									end else begin
										state_q <= S_DONE;
									end
								end
							end
							OP_PREEMPT: begin
								if (cpu_ok && !in_busy) begin
									state_q <= S_DISP;
								end else if (cpu_ok && !q_full) begin
									state_q <= S_PRE_PUSH;
								end else begin
									res_act_q <= ACT_FULL;
									res_cpu_q <= cpu_index;
									state_q   <= S_DONE;
								end
							end
							OP_YIELD, OP_TERM: begin
								state_q <= cpu_ok ? S_DISP : S_DONE;
							end
							OP_IDLE: begin
								state_q <= (cpu_ok && count_q != '0) ? S_DISP : S_DONE;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_PRE_PUSH: begin
					count_q <= count_q + QCW'(1);
					state_q <= S_DISP;
				end
				S_CPU_SCAN: begin
					if (cidx_q < n_eff) begin
						cidx_q  <= cidx_q + NCPU_W'(1);
						cv_s1   <= 1'b1;
						cidx_s1 <= cidx_q;
					end else begin
						cv_s1 <= 1'b0;
					end
					if (cv_s1) begin
						if (prio_q < c_rd_prio) begin
							urgent_q <= 1'b1;
						end
						if (c_rd_prio > bestp_q) begin
							bestp_q <= c_rd_prio;
							bestc_q <= cidx_s1;
						end
						if (cidx_s1 == n_eff - NCPU_W'(1)) begin
							state_q <= S_CPU_FIN;
						end
					end
				end
				S_CPU_FIN: begin
					if (urgent_q) begin
						res_pend_q <= 1'b1;
						res_act_q  <= ACT_PREEMPT;
						res_cpu_q  <= bestc_q[CPU_W-1:0];
					end
					state_q <= S_DONE;
				end
				S_DISP: begin
					if (count_q == '0) begin
						res_pend_q <= 1'b1;
						res_act_q  <= ACT_IDLE;
						res_cpu_q  <= cpu_q;
						state_q    <= S_DONE;
					end else begin
						idx_q   <= '0;
						limit_q <= (mode_q == MODE_PRIO) ? count_q : QCW'(1);
						v_s1    <= 1'b0;
						state_q <= S_Q_SCAN;
					end
				end
				S_Q_SCAN: begin
					if (idx_q < limit_q) begin
						idx_q   <= idx_q + QCW'(1);
						v_s1    <= 1'b1;
						qidx_s1 <= idx_q[QAW-1:0];
					end else begin
						v_s1 <= 1'b0;
					end
					if (v_s1) begin
						if (qidx_s1 == '0 || q_rd_prio < best_prio_q) begin
							best_pos_q  <= qidx_s1;
							best_id_q   <= q_rd_id;
							best_prio_q <= q_rd_prio;
						end
						if (QCW'(qidx_s1) == limit_q - QCW'(1)) begin
							state_q <= S_TAKE;
						end
					end
				end
				S_TAKE: begin
					res_pend_q  <= 1'b1;
					res_act_q   <= ACT_DISPATCH;
					res_cpu_q   <= cpu_q;
					res_id_q    <= best_id_q;
					res_slice_q <= slice_q;
					if (next_pos < count_q) begin
						idx_q   <= next_pos;
						v_s1    <= 1'b0;
						state_q <= S_SHIFT;
					end else begin
						count_q <= count_q - QCW'(1);
						state_q <= S_DONE;
					end
				end
				S_SHIFT: begin
					if (idx_q < count_q) begin
						idx_q   <= idx_q + QCW'(1);
						v_s1    <= 1'b1;
						qidx_s1 <= idx_m1[QAW-1:0];
					end else begin
						v_s1 <= 1'b0;
					end
					if (v_s1 && QCW'(qidx_s1) == count_q - QCW'(2)) begin
						count_q <= count_q - QCW'(1);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!res_pend_q) begin
						state_q <= S_IDLE;
					end else if (!result_valid_q || !result_stall) begin
						result_valid_q  <= 1'b1;
						action_q        <= res_act_q;
						target_cpu_q    <= res_cpu_q;
						dispatched_id_q <= res_id_q;
						slice_out_q     <= res_slice_q;
						state_q         <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	mcrqs_ready_mem #(
		.MAX_PROCS (MAX_PROCS),
		.PRIO_BITS (PRIO_BITS)
	) u_ready_mem (
		.clk     (clk),
		.cmd     (q_cmd),
		.wr_addr (q_wr_addr),
		.wr_id   (q_wr_id),
		.wr_prio (q_wr_prio),
		.rd_addr (q_rd_addr),
		.rd_id   (q_rd_id),
		.rd_prio (q_rd_prio)
	);

	mcrqs_cpu_tab #(
		.MAX_CPUS  (MAX_CPUS),
		.PRIO_BITS (PRIO_BITS)
	) u_cpu_tab (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (c_cmd),
		.cpu_addr (c_addr),
		.wr_id    (best_id_q),
		.wr_prio  (best_prio_q),
		.rd_addr  (c_rd_addr),
		.rd_id    (c_rd_id),
		.rd_prio  (c_rd_prio),
		.busy     (busy)
	);

	assign result_valid  = result_valid_q;
	assign action        = action_q;
	assign target_cpu    = target_cpu_q;
	assign dispatched_id = dispatched_id_q;
	assign slice_out     = slice_out_q;

endmodule

// ===== rtl/mcrqs_ready_mem.sv =====
`timescale 1ns / 1ps

module mcrqs_ready_mem #(
	parameter int MAX_PROCS = mcrqs_pkg::MAX_PROCS_DEF,
	parameter int PRIO_BITS = mcrqs_pkg::PRIO_BITS_DEF,
	localparam int AW = $clog2(MAX_PROCS)
) (
	input  logic                       clk,
	input  mcrqs_pkg::mem_cmd_t        cmd,
	input  logic [AW-1:0]              wr_addr,
	input  logic [mcrqs_pkg::PID_W-1:0] wr_id,
	input  logic [PRIO_BITS-1:0]       wr_prio,
	input  logic [AW-1:0]              rd_addr,
	output logic [mcrqs_pkg::PID_W-1:0] rd_id,
	output logic [PRIO_BITS-1:0]       rd_prio
);
	import mcrqs_pkg::*;

	localparam int DW = PID_W + PRIO_BITS;

	logic [DW-1:0] mem [MAX_PROCS];
	logic [DW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= {wr_id, wr_prio};
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_id   = rd_q[DW-1:PRIO_BITS];
	assign rd_prio = rd_q[PRIO_BITS-1:0];

endmodule

// ===== rtl/mcrqs_cpu_tab.sv =====
`timescale 1ns / 1ps

module mcrqs_cpu_tab #(
	parameter int MAX_CPUS  = mcrqs_pkg::MAX_CPUS_DEF,
	parameter int PRIO_BITS = mcrqs_pkg::PRIO_BITS_DEF,
	localparam int CAW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mcrqs_pkg::cpu_cmd_t         cmd,
	input  logic [CAW-1:0]              cpu_addr,
	input  logic [mcrqs_pkg::PID_W-1:0] wr_id,
	input  logic [PRIO_BITS-1:0]        wr_prio,
	input  logic [CAW-1:0]              rd_addr,
	output logic [mcrqs_pkg::PID_W-1:0] rd_id,
	output logic [PRIO_BITS-1:0]        rd_prio,
	output logic [MAX_CPUS-1:0]         busy
);
	import mcrqs_pkg::*;

	localparam int DW = PID_W + PRIO_BITS;

	logic [DW-1:0]       mem [MAX_CPUS];
	logic [DW-1:0]       rd_q;
	logic [MAX_CPUS-1:0] busy_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cpu_addr] <= {wr_id, wr_prio};
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else if (cmd.set_busy) begin
			busy_q[cpu_addr] <= 1'b1;
		end else if (cmd.clr_busy) begin
			busy_q[cpu_addr] <= 1'b0;
		end
	end

	assign rd_id   = rd_q[DW-1:PRIO_BITS];
	assign rd_prio = rd_q[PRIO_BITS-1:0];
	assign busy    = busy_q;

endmodule

// ===== rtl/mcrqs_checker.sv =====
`timescale 1ns / 1ps

module mcrqs_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              cfg_wr_en,
	input logic [mcrqs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input logic [mcrqs_pkg::CFG_DATA_W-1:0]  cfg_data,
	input logic                              item_valid,
	input logic                              item_stall,
	input logic                              result_valid,
	input logic                              result_stall,
	input logic [mcrqs_pkg::ACT_W-1:0]       action,
	input logic [mcrqs_pkg::PID_W-1:0]       dispatched_id,
	input logic [mcrqs_pkg::SLICE_W-1:0]     slice_out
);
	import mcrqs_pkg::*;

	logic [SLICE_W-1:0] slice_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_q <= '0;
		end else if (cfg_wr_en && cfg_index == REG_SLICE) begin
			slice_q <= cfg_data[SLICE_W-1:0];
		end
	end

	a_hold_beat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result beat dropped while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item taken while previous item in flight");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && action != ACT_DISPATCH |-> dispatched_id == '0 && slice_out == '0)
		else $error("non-dispatch beat carries id or slice");

	a_slice: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && action == ACT_DISPATCH |-> slice_out == slice_q)
		else $error("dispatch slice differs from programmed slice");

endmodule

bind multi_cpu_ready_queue_scheduler mcrqs_checker u_mcrqs_checker (.*);
